FILE: src/atl_pkg.sv
// Package for the assembler token lexer: item structs, token and result codes,
// lexer mode enum and character class helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package atl_pkg;

   localparam int MaxTextDefault = 127;
   localparam int ResultSlots = 3;

   localparam logic [7:0] ChNewline = 8'h0a;
   localparam logic [7:0] ChDollar = 8'h24;
   localparam logic [7:0] ChSemi = 8'h3b;
   localparam logic [7:0] ChComma = 8'h2c;
   localparam logic [7:0] ChAt = 8'h40;
   localparam logic [7:0] ChPlus = 8'h2b;
   localparam logic [7:0] ChMinus = 8'h2d;
   localparam logic [7:0] ChDot = 8'h2e;
   localparam logic [7:0] ChColon = 8'h3a;
   localparam logic [7:0] ChQuote = 8'h27;
   localparam logic [7:0] ChUnder = 8'h5f;

   typedef enum logic [1:0] {
      KIND_TEXT = 2'd0,
      KIND_DONE = 2'd1,
      KIND_EOL  = 2'd2
   } result_kind_type;

   typedef enum logic [3:0] {
      TOK_IDENT  = 4'd0,
      TOK_DIR    = 4'd1,
      TOK_DEC    = 4'd2,
      TOK_HEX    = 4'd3,
      TOK_LABEL  = 4'd4,
      TOK_COMMA  = 4'd5,
      TOK_PLUS   = 4'd6,
      TOK_MINUS  = 4'd7,
      TOK_AT     = 4'd8,
      TOK_STRING = 4'd9
   } token_type_type;

   typedef enum logic [2:0] {
      MODE_TOP     = 3'd0,
      MODE_IDENT   = 3'd1,
      MODE_DIR     = 3'd2,
      MODE_DEC     = 3'd3,
      MODE_HEX     = 3'd4,
      MODE_STRING  = 3'd5,
      MODE_COMMENT = 3'd6
   } lexer_mode_type;

   typedef struct packed {
      logic [7:0] in_char;
      logic       at_end;
   } req_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] text_char;
      logic [3:0] token_type;
      logic [6:0] token_length;
      logic       last;
   } rsp_type;

   function automatic logic [7:0] fold_upper(input logic [7:0] c);
      logic [7:0] u;
      u = c;
      if (c >= 8'h61 && c <= 8'h7a) begin
         u = c - 8'd32;
      end
      return u;
   endfunction

   function automatic logic is_alpha(input logic [7:0] u);
      return (u >= 8'h41) && (u <= 8'h5a);
   endfunction

   function automatic logic is_digit(input logic [7:0] u);
      return (u >= 8'h30) && (u <= 8'h39);
   endfunction

   function automatic logic is_hex(input logic [7:0] u);
      return is_digit(u) || ((u >= 8'h41) && (u <= 8'h46));
   endfunction

endpackage
`default_nettype wire

FILE: src/assembler_token_lexer_unit.sv
// Assembler token lexer top level: character decode, lexer mode register and a
// three-entry result buffer draining one item per unstalled cycle. Depends on atl_pkg.
`timescale 1ns / 1ps
`default_nettype none
//  channel  direction  payload   handshake
//  req      in         req_type  req_valid / req_stall
//  rsp      out        rsp_type  rsp_valid / rsp_stall
//
//  One character item is decoded in the cycle it is accepted; its zero to three
//  results land in the result buffer and leave one per unstalled cycle from the next
//  cycle on. A character with one result or none sustains one item per unstalled
//  cycle; with two or three results the buffer drain sets the pace.
//  Synchronous reset clears the lexer mode, the text count and the buffer fill.
//  req_stall is high while the buffer holds more than the result leaving this cycle.
module assembler_token_lexer_unit import atl_pkg::*; #(
   parameter int MAX_TEXT = MaxTextDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int CW = $clog2(MAX_TEXT + 1);
   localparam logic [CW-1:0] MaxCount = CW'(MAX_TEXT);
   localparam logic [CW-1:0] OneCount = CW'(1);

   lexer_mode_type mode_ff, mode_in;
   logic [CW-1:0]  count_ff, count_in;
   rsp_type        slot_ff [ResultSlots];
   rsp_type        slot_in [ResultSlots];
   logic [1:0]     fill_ff, fill_in;

   logic       accept, pop;
   logic [7:0] c, u;
   logic       at_end;
   logic       stay, label_done, fin_a, again, eol_a, has_room;
   logic [7:0] keep_char;
   token_type_type type_a;
   logic       single;
   token_type_type single_type;

   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = !((fill_ff == 2'd0) || ((fill_ff == 2'd1) && pop));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (fill_ff != 2'd0);
   assign rsp_data  = slot_ff[0];

   assign c        = req_data.in_char;
   assign at_end   = req_data.at_end;
   assign u        = fold_upper(c);
   assign has_room = (count_ff < MaxCount);

   // decode current mode against the character
   always_comb begin
      stay       = 1'b0;
      label_done = 1'b0;
      fin_a      = 1'b0;
      again      = 1'b0;
      eol_a      = 1'b0;
      type_a     = TOK_IDENT;
      keep_char  = u;
      case (mode_ff)
         MODE_IDENT: begin
            type_a = TOK_IDENT;
            if (!at_end && (is_alpha(u) || is_digit(u) || u == ChUnder)) begin
               stay = 1'b1;
            end else if (!at_end && u == ChColon) begin
               fin_a      = 1'b1;
               label_done = 1'b1;
               type_a     = TOK_LABEL;
            end else begin
               fin_a = 1'b1;
               again = 1'b1;
            end
         end
         MODE_DIR: begin
            type_a = TOK_DIR;
            stay   = !at_end && is_alpha(u);
            fin_a  = !stay;
            again  = !stay;
         end
         MODE_DEC: begin
            type_a = TOK_DEC;
            stay   = !at_end && is_digit(u);
            fin_a  = !stay;
            again  = !stay;
         end
         MODE_HEX: begin
            type_a = TOK_HEX;
            stay   = !at_end && is_hex(u);
            fin_a  = !stay;
            again  = !stay;
         end
         MODE_STRING: begin
            type_a    = TOK_STRING;
            keep_char = c;
            if (at_end) begin
               fin_a = 1'b1;
               again = 1'b1;
            end else if (c == ChQuote) begin
               fin_a      = 1'b1;
               label_done = 1'b1;
            end else begin
               stay = 1'b1;
            end
         end
         MODE_COMMENT: begin
            eol_a = at_end;
         end
         default: begin
            again = 1'b1;
         end
      endcase
   end

   always_comb begin
      single      = 1'b1;
      single_type = TOK_PLUS;
      case (u)
         ChPlus:  single_type = TOK_PLUS;
         ChMinus: single_type = TOK_MINUS;
         ChAt:    single_type = TOK_AT;
         ChComma: single_type = TOK_COMMA;
         default: single = 1'b0;
      endcase
   end

   // next lexer state
   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      if (accept) begin
         if (stay) begin
            if (has_room) begin
               count_in = count_ff + OneCount;
            end
         end else if (label_done || eol_a) begin
            mode_in  = MODE_TOP;
            count_in = '0;
         end else if (again) begin
            mode_in  = MODE_TOP;
            count_in = '0;
            if (at_end || u == ChNewline) begin
               mode_in = MODE_TOP;
            end else if (is_alpha(u)) begin
               mode_in  = MODE_IDENT;
               count_in = OneCount;
            end else if (is_digit(u)) begin
               mode_in  = MODE_DEC;
               count_in = OneCount;
            end else if (u == ChDot) begin
               mode_in  = MODE_DIR;
               count_in = OneCount;
            end else if (u == ChDollar) begin
               mode_in = MODE_HEX;
            end else if (u == ChSemi) begin
               mode_in = MODE_COMMENT;
            end else if (u == ChQuote) begin
               mode_in = MODE_STRING;
            end
         end
      end
   end

   // results and buffer
   always_comb begin
      rsp_type    r [ResultSlots];
      logic [1:0] n;
      rsp_type    blank;
      blank = '0;
      n     = 2'd0;
      for (int i = 0; i < ResultSlots; i++) begin
         r[i] = blank;
      end
      if (stay && has_room) begin
         r[n].result_kind = KIND_TEXT;
         r[n].text_char   = keep_char;
         n = n + 2'd1;
      end
      if (fin_a) begin
         r[n].result_kind  = KIND_DONE;
         r[n].token_type   = type_a;
         r[n].token_length = 7'(count_ff);
         n = n + 2'd1;
      end
      if (eol_a) begin
         r[n].result_kind = KIND_EOL;
         n = n + 2'd1;
      end
      if (again) begin
         if (at_end || u == ChNewline) begin
            r[n].result_kind = KIND_EOL;
            n = n + 2'd1;
         end else if (is_alpha(u) || is_digit(u) || u == ChDot || single) begin
            r[n].result_kind = KIND_TEXT;
            r[n].text_char   = u;
            n = n + 2'd1;
            if (single && n != 2'd3) begin
               r[n].result_kind  = KIND_DONE;
               r[n].token_type   = single_type;
               r[n].token_length = 7'd1;
               n = n + 2'd1;
            end
         end
      end
      if (n != 2'd0) begin
         r[n - 2'd1].last = 1'b1;
      end

      fill_in = fill_ff;
      for (int i = 0; i < ResultSlots; i++) begin
         slot_in[i] = slot_ff[i];
      end
      if (accept) begin
         fill_in = n;
         for (int i = 0; i < ResultSlots; i++) begin
            slot_in[i] = r[i];
         end
      end else if (pop) begin
         fill_in = fill_ff - 2'd1;
         for (int i = 0; i < ResultSlots - 1; i++) begin
            slot_in[i] = slot_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_TOP;
         count_ff <= '0;
         fill_ff  <= 2'd0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ResultSlots; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

endmodule
`default_nettype wire
